>>> hdl/triangulation_matting_pixel_top_defines.svh
// Assertion macros shared by the triangulation matting checker.
`ifndef TRIANGULATION_MATTING_PIXEL_TOP_DEFINES_SVH
`define TRIANGULATION_MATTING_PIXEL_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define TRIMAT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("triangulation matting check failed");

// Checked at every clock edge, reset included.
`define TRIMAT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("triangulation matting check failed");

`endif

>>> hdl/trimat_pkg.sv
// Package with widths and pipeline lane types for triangulation matting.
`timescale 1ns / 1ps
package trimat_pkg;
  localparam int CHAN_BITS = 8;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;
  localparam int LANES = 4;
  localparam int ALPHA_LANE = 3;
  localparam int REM_BITS = 28;
  localparam int DIV_BITS = 19;
  localparam int QUO_BITS = CHAN_BITS;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [DIV_BITS-1:0] dvs;
    logic [QUO_BITS-1:0] quo;
    logic                fix;
    logic [QUO_BITS-1:0] fix_val;
  } lane_t;
endpackage

>>> hdl/triangulation_matting_pixel_top.sv
// Top level of the pipelined triangulation matting pixel solver.
`timescale 1ns / 1ps
//  channel  | signals                                   | handshake
//  request  | start, busy, twelve 8-bit sample ports    | taken when start and not busy
//  result   | done, fg_red/green/blue, alpha_level,      | shown for one cycle on done
//           | backs_equal                               |
// A new request can be taken in every cycle; busy is high only during reset.
// Each result passes through five arithmetic stages followed by eight
// restoring divider stages, one quotient bit each, and the output register.
// Reset empties the pipeline and drops requests in flight.
// Results cannot be held off, and the pipeline never stalls.
module triangulation_matting_pixel_top
  import trimat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CHAN_BITS-1:0] first_comp_red,
  input  logic [CHAN_BITS-1:0] first_comp_green,
  input  logic [CHAN_BITS-1:0] first_comp_blue,
  input  logic [CHAN_BITS-1:0] second_comp_red,
  input  logic [CHAN_BITS-1:0] second_comp_green,
  input  logic [CHAN_BITS-1:0] second_comp_blue,
  input  logic [CHAN_BITS-1:0] first_back_red,
  input  logic [CHAN_BITS-1:0] first_back_green,
  input  logic [CHAN_BITS-1:0] first_back_blue,
  input  logic [CHAN_BITS-1:0] second_back_red,
  input  logic [CHAN_BITS-1:0] second_back_green,
  input  logic [CHAN_BITS-1:0] second_back_blue,
  output logic                 done,
  output logic [CHAN_BITS-1:0] fg_red,
  output logic [CHAN_BITS-1:0] fg_green,
  output logic [CHAN_BITS-1:0] fg_blue,
  output logic [CHAN_BITS-1:0] alpha_level,
  output logic                 backs_equal
);

  logic [CHAN_BITS-1:0] c1 [3];
  logic [CHAN_BITS-1:0] c2 [3];
  logic [CHAN_BITS-1:0] b1 [3];
  logic [CHAN_BITS-1:0] b2 [3];

  assign c1[0] = first_comp_red;
  assign c1[1] = first_comp_green;
  assign c1[2] = first_comp_blue;
  assign c2[0] = second_comp_red;
  assign c2[1] = second_comp_green;
  assign c2[2] = second_comp_blue;
  assign b1[0] = first_back_red;
  assign b1[1] = first_back_green;
  assign b1[2] = first_back_blue;
  assign b2[0] = second_back_red;
  assign b2[1] = second_back_green;
  assign b2[2] = second_back_blue;

  assign busy = rst;

  logic signed [8:0]  dc [3];
  logic signed [8:0]  db [3];
  logic signed [17:0] pn_next [3];
  logic signed [17:0] pd_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dc[k] = $signed({1'b0, c1[k]}) - $signed({1'b0, c2[k]});
      db[k] = $signed({1'b0, b1[k]}) - $signed({1'b0, b2[k]});
      pn_next[k] = dc[k] * db[k];
      pd_next[k] = db[k] * db[k];
    end
  end

  // Stage 1: per-channel products and sums.
  logic               v1;
  logic signed [17:0] pn [3];
  logic [15:0]        pd [3];
  logic [8:0]         sc1 [3];
  logic [8:0]         sb1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    for (int k = 0; k < 3; k++) begin
      pn[k]  <= pn_next[k];
      pd[k]  <= pd_next[k][15:0];
      sc1[k] <= {1'b0, c1[k]} + {1'b0, c2[k]};
      sb1[k] <= {1'b0, b1[k]} + {1'b0, b2[k]};
    end
  end

  // Stage 2: dot products.
  logic               v2;
  logic signed [19:0] num;
  logic [17:0]        den;
  logic [8:0]         sc2 [3];
  logic [8:0]         sb2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    num <= 20'(pn[0]) + 20'(pn[1]) + 20'(pn[2]);
    den <= 18'(pd[0]) + 18'(pd[1]) + 18'(pd[2]);
    sc2 <= sc1;
    sb2 <= sb1;
  end

  logic signed [29:0] nb_next [3];
  logic signed [20:0] an;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nb_next[k] = num * $signed({1'b0, sb2[k]});
    end
    an = $signed({3'b000, den}) - num;
  end

  // Stage 3: numerator products and alpha scaling.
  logic               v3;
  logic [26:0]        pc [3];
  logic signed [29:0] nb [3];
  logic signed [29:0] an255;
  logic               a_zero3;
  logic               a_full3;
  logic               eq3;
  logic [17:0]        den3;
  logic [7:0]         half3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int k = 0; k < 3; k++) begin
      pc[k]    <= 27'(den) * 27'(sc2[k]);
      nb[k]    <= nb_next[k];
      half3[k] <= sc2[k][8:1];
    end
    an255   <= (30'(an) <<< 8) - 30'(an);
    a_zero3 <= num >= $signed({2'b00, den});
    a_full3 <= num <= 0;
    eq3     <= den == '0;
    den3    <= den;
  end

  // Stage 4: foreground numerators.
  logic               v4;
  logic signed [30:0] fn [3];
  logic [DIV_BITS-1:0] fd;
  logic signed [29:0] an4;
  logic               a_zero4;
  logic               a_full4;
  logic               eq4;
  logic [17:0]        den4;
  logic [7:0]         half4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int k = 0; k < 3; k++) begin
      fn[k] <= $signed({4'b0000, pc[k]}) - 31'(nb[k]);
    end
    fd      <= {den3, 1'b0};
    an4     <= an255;
    a_zero4 <= a_zero3;
    a_full4 <= a_full3;
    eq4     <= eq3;
    den4    <= den3;
    half4   <= half3;
  end

  // Stage 5 and divider stages.
  lane_t lane_next [LANES];
  lane_t lanes [9][LANES];
  logic  dv [9];
  logic  deq [9];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_next[k].rem     = fn[k][REM_BITS-1:0];
      lane_next[k].dvs     = fd;
      lane_next[k].quo     = '0;
      lane_next[k].fix     = 1'b1;
      lane_next[k].fix_val = '0;
      if (eq4) begin
        lane_next[k].fix_val = half4[k];
      end else if (fn[k] <= 0) begin
        lane_next[k].fix_val = '0;
      end else if (fn[k] >= $signed({4'b0000, fd, 8'b0})) begin
        lane_next[k].fix_val = CHAN_MAX;
      end else begin
        lane_next[k].fix = 1'b0;
      end
    end
    lane_next[ALPHA_LANE].rem     = an4[REM_BITS-1:0];
    lane_next[ALPHA_LANE].dvs     = {1'b0, den4};
    lane_next[ALPHA_LANE].quo     = '0;
    lane_next[ALPHA_LANE].fix     = eq4 | a_zero4 | a_full4;
    lane_next[ALPHA_LANE].fix_val = (eq4 | a_full4) ? CHAN_MAX : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v4;
    end
    deq[0]   <= eq4;
    lanes[0] <= lane_next;
  end

  for (genvar s = 0; s < 8; s++) begin : g_div
    localparam int BIT = 7 - s;
    lane_t step [LANES];

    always_comb begin
      logic [REM_BITS-1:0] sub;
      for (int k = 0; k < LANES; k++) begin
        sub = REM_BITS'(lanes[s][k].dvs) << BIT;
        step[k] = lanes[s][k];
        if (lanes[s][k].rem >= sub) begin
          step[k].rem      = lanes[s][k].rem - sub;
          step[k].quo[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else begin
        dv[s+1] <= dv[s];
      end
      deq[s+1]   <= deq[s];
      lanes[s+1] <= step;
    end
  end

  // Output register.
  logic [CHAN_BITS-1:0] res [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      res[k] = lanes[8][k].fix ? lanes[8][k].fix_val : lanes[8][k].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[8];
    end
    fg_red      <= res[0];
    fg_green    <= res[1];
    fg_blue     <= res[2];
    alpha_level <= res[ALPHA_LANE];
    backs_equal <= deq[8];
  end

endmodule

>>> hdl/trimat_checker.sv
// Port-level checker for the triangulation matting pixel solver, with its bind.
`timescale 1ns / 1ps
`include "triangulation_matting_pixel_top_defines.svh"
module trimat_checker
  import trimat_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [CHAN_BITS-1:0] alpha_level,
  input logic                 backs_equal
);

  `TRIMAT_ASSERT(busy_only_in_reset, clk, rst, !busy)
  `TRIMAT_ASSERT(equal_backs_opaque, clk, rst, (done && backs_equal) |-> (alpha_level == CHAN_MAX))
  `TRIMAT_ASSERT(request_gives_result, clk, rst, (start && !busy) |-> ##14 done)
  `TRIMAT_ASSERT_ALWAYS(reset_flushes_results, clk, rst |=> !done)
  `TRIMAT_ASSERT_ALWAYS(reset_blocks_requests, clk, rst |-> busy)

endmodule

bind triangulation_matting_pixel_top trimat_checker u_trimat_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .alpha_level(alpha_level),
  .backs_equal(backs_equal)
);

>>> dv/triangulation_matting_pixel_top_tb.sv
// Self-checking testbench for the triangulation matting pixel solver.
`timescale 1ns / 1ps
module triangulation_matting_pixel_top_tb;
  import trimat_pkg::*;

  typedef logic [CHAN_BITS-1:0] chan_t;

  typedef struct {
    chan_t c1 [3];
    chan_t c2 [3];
    chan_t b1 [3];
    chan_t b2 [3];
  } pixel_t;

  typedef struct {
    chan_t fg [3];
    chan_t alpha;
    logic  flat;
  } matte_t;

  localparam int LATENCY = 14;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  chan_t cr1 = '0, cg1 = '0, cb1 = '0, cr2 = '0, cg2 = '0, cb2 = '0;
  chan_t br1 = '0, bg1 = '0, bb1 = '0, br2 = '0, bg2 = '0, bb2 = '0;
  logic done;
  chan_t fg_red, fg_green, fg_blue, alpha_level;
  logic backs_equal;

  matte_t pending_mattes[$];
  int errors = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangulation_matting_pixel_top DUT (
    .clk, .rst, .start, .busy,
    .first_comp_red(cr1), .first_comp_green(cg1), .first_comp_blue(cb1),
    .second_comp_red(cr2), .second_comp_green(cg2), .second_comp_blue(cb2),
    .first_back_red(br1), .first_back_green(bg1), .first_back_blue(bb1),
    .second_back_red(br2), .second_back_green(bg2), .second_back_blue(bb2),
    .done, .fg_red, .fg_green, .fg_blue, .alpha_level, .backs_equal
  );

  function automatic matte_t solve_matte(pixel_t p);
    matte_t m;
    longint num, den, an, fn;
    num = 0;
    den = 0;
    for (int k = 0; k < 3; k++) begin
      num += (longint'(p.c1[k]) - longint'(p.c2[k]))
             * (longint'(p.b1[k]) - longint'(p.b2[k]));
      den += (longint'(p.b1[k]) - longint'(p.b2[k]))
             * (longint'(p.b1[k]) - longint'(p.b2[k]));
    end
    m.flat = (den == 0);
    if (den == 0) begin
      m.alpha = CHAN_MAX;
      for (int k = 0; k < 3; k++) m.fg[k] = chan_t'((longint'(p.c1[k]) + p.c2[k]) / 2);
    end else begin
      an = den - num;
      if (an <= 0) m.alpha = '0;
      else if (an >= den) m.alpha = CHAN_MAX;
      else m.alpha = chan_t'((an * 255) / den);
      for (int k = 0; k < 3; k++) begin
        fn = den * (longint'(p.c1[k]) + p.c2[k]) - num * (longint'(p.b1[k]) + p.b2[k]);
        if (fn <= 0) m.fg[k] = '0;
        else if (fn / (2 * den) > 255) m.fg[k] = CHAN_MAX;
        else m.fg[k] = chan_t'(fn / (2 * den));
      end
    end
    return m;
  endfunction

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {cr1, cg1, cb1} <= {p.c1[0], p.c1[1], p.c1[2]};
    {cr2, cg2, cb2} <= {p.c2[0], p.c2[1], p.c2[2]};
    {br1, bg1, bb1} <= {p.b1[0], p.b1[1], p.b1[2]};
    {br2, bg2, bb2} <= {p.b2[0], p.b2[1], p.b2[2]};
    do @(posedge clk); while (busy);
    pending_mattes.push_back(solve_matte(p));
  endtask

  function automatic pixel_t fill_pixel(chan_t v);
    pixel_t p;
    for (int k = 0; k < 3; k++) begin
      p.c1[k] = v; p.c2[k] = v; p.b1[k] = v; p.b2[k] = v;
    end
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    for (int k = 0; k < 3; k++) begin
      p.c1[k] = $urandom; p.c2[k] = $urandom; p.b1[k] = $urandom; p.b2[k] = $urandom;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    matte_t m;
    if (!rst && done) begin
      if (pending_mattes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual fg %0d %0d %0d alpha %0d",
                 $time, fg_red, fg_green, fg_blue, alpha_level);
        errors++;
      end else begin
        m = pending_mattes.pop_front();
        if ({fg_red, fg_green, fg_blue, alpha_level, backs_equal} !==
            {m.fg[0], m.fg[1], m.fg[2], m.alpha, m.flat}) begin
          $display({"%0t: mismatch, expected fg %0d %0d %0d alpha %0d flag %0b,",
                    " actual fg %0d %0d %0d alpha %0d flag %0b"},
                   $time, m.fg[0], m.fg[1], m.fg[2], m.alpha, m.flat,
                   fg_red, fg_green, fg_blue, alpha_level, backs_equal);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** triangulation_matting_pixel_top: FAILED **");
      $finish;
    end
  end

  task automatic test_extremes();
    pixel_t p;
    send_pixel(fill_pixel('0));
    send_pixel(fill_pixel(CHAN_MAX));
    p = fill_pixel('0);
    for (int k = 0; k < 3; k++) begin
      p.c1[k] = CHAN_MAX; p.b1[k] = CHAN_MAX;
    end
    send_pixel(p);
    p = fill_pixel(CHAN_MAX);
    for (int k = 0; k < 3; k++) begin
      p.c1[k] = '0; p.b1[k] = '0;
    end
    send_pixel(p);
  endtask

  task automatic test_equal_backgrounds();
    pixel_t p;
    for (int i = 0; i < 5; i++) begin
      p = random_pixel();
      p.b2 = p.b1;
      send_pixel(p);
    end
    p = fill_pixel(CHAN_MAX);
    p.c2[0] = 8'd254;
    p.b1[1] = '0; p.b2[1] = '0;
    send_pixel(p);
  endtask

  task automatic test_alpha_out_of_range();
    pixel_t p;
    p = fill_pixel('0);
    p.b1[0] = 8'd10; p.c1[0] = CHAN_MAX;
    send_pixel(p);
    p = fill_pixel('0);
    p.b1[2] = CHAN_MAX; p.c2[2] = CHAN_MAX;
    send_pixel(p);
    p = fill_pixel(8'd128);
    p.b1[1] = 8'd129; p.c1[1] = CHAN_MAX; p.c2[0] = CHAN_MAX; p.c1[0] = CHAN_MAX;
    send_pixel(p);
    for (int i = 0; i < 6; i++) begin
      p = random_pixel();
      p.b2[0] = p.b1[0] ^ 8'h01;
      p.b2[1] = p.b1[1];
      p.b2[2] = p.b1[2];
      send_pixel(p);
    end
  endtask

  task automatic test_random();
    pixel_t p;
    for (int i = 0; i < 1000; i++) begin
      p = random_pixel();
      case ($urandom_range(0, 9))
        0: p.b2 = p.b1;
        1: for (int k = 0; k < 3; k++) p.b2[k] = p.b1[k] + chan_t'($urandom_range(0, 4)) - 8'd2;
        2: p.c2 = p.b2;
        default: ;
      endcase
      send_pixel(p);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_equal_backgrounds();
    test_alpha_out_of_range();
    test_random();
    start <= 1'b0;
    while (pending_mattes.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && pending_mattes.size() == 0) begin
      $display("** triangulation_matting_pixel_top: PASSED **");
    end else begin
      $display("** triangulation_matting_pixel_top: FAILED **");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/trimat_pkg.sv
hdl/triangulation_matting_pixel_top.sv
hdl/trimat_checker.sv
dv/triangulation_matting_pixel_top_tb.sv
